### hw/rtl/ard_pkg.sv
// ============================================================================
// ard_pkg - shared types and codes for the automaton record deserializer
// Request structs for both channels, the front-to-back command, and the
// element kind, error and hold codes used by more than one file.
// ============================================================================
package ard_pkg;

    // Element kinds reported with each result
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_ALPHA  = 3'd1;
    localparam logic [2:0] KIND_SCOUNT = 3'd2;
    localparam logic [2:0] KIND_INIT   = 3'd3;
    localparam logic [2:0] KIND_FINAL  = 3'd4;
    localparam logic [2:0] KIND_TRANS  = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LEN_SHORT = 3'd1;
    localparam logic [2:0] ERR_TRUNC     = 3'd2;
    localparam logic [2:0] ERR_LEN_LONG  = 3'd3;
    localparam logic [2:0] ERR_STATE     = 3'd4;
    localparam logic [2:0] ERR_TRANS     = 3'd5;

    // What the back end latches from a command word
    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_SRC   = 2'd1;
    localparam logic [1:0] HOLD_LABEL = 2'd2;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic signed [31:0] word;
        logic               last_in_buffer;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         elem_kind;
        logic signed [31:0] elem_value;
        logic signed [31:0] trans_source;
        logic signed [31:0] trans_label;
        logic signed [31:0] trans_dest;
        logic               record_done;
        logic [2:0]         error_code;
    } t_out_req;

    // Classified word handed from front to back
    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         hold;
        logic signed [31:0] word;
        logic               done;
        logic [2:0]         err;
    } t_cmd;

endpackage

### hw/rtl/ard_front.sv
// ============================================================================
// ard_front - record parser
// Tracks the record phase and word/item counters, range-checks length, state
// and transition words; each word becomes one classified back-end command.
// ============================================================================
module ard_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ard_pkg::t_in_req i_req,
    output ard_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] PH_LEN    = 4'd0;
    localparam logic [3:0] PH_ALPHA  = 4'd1;
    localparam logic [3:0] PH_SCOUNT = 4'd2;
    localparam logic [3:0] PH_ICOUNT = 4'd3;
    localparam logic [3:0] PH_IST    = 4'd4;
    localparam logic [3:0] PH_FCOUNT = 4'd5;
    localparam logic [3:0] PH_FST    = 4'd6;
    localparam logic [3:0] PH_TCOUNT = 4'd7;
    localparam logic [3:0] PH_TSRC   = 4'd8;
    localparam logic [3:0] PH_TLAB   = 4'd9;
    localparam logic [3:0] PH_TDST   = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [31:0] r_words_left, n_words_left;
    logic [31:0] r_alpha, n_alpha;
    logic [31:0] r_scount, n_scount;
    logic [31:0] r_items_left, n_items_left;
    logic        r_src_ok, n_src_ok;
    logic        r_lab_ok, n_lab_ok;

    logic signed [31:0] s;
    logic signed [31:0] sc;
    logic signed [31:0] alpha_s;
    logic [31:0] items_dec;
    logic [31:0] words_dec;
    logic [3:0]  next_ph;
    logic [2:0]  kind;
    logic [1:0]  hold;
    logic [2:0]  err;
    logic        done;
    logic        final_word;
    logic        in_record;

    assign s       = i_req.word;
    assign sc      = $signed(r_scount);
    assign alpha_s = $signed(r_alpha);

    // Classify the word against the current phase
    always_comb begin
        n_phase      = r_phase;
        n_words_left = r_words_left;
        n_alpha      = r_alpha;
        n_scount     = r_scount;
        n_items_left = r_items_left;
        n_src_ok     = r_src_ok;
        n_lab_ok     = r_lab_ok;
        kind         = ard_pkg::KIND_NONE;
        hold         = ard_pkg::HOLD_NONE;
        err          = ard_pkg::ERR_NONE;
        done         = 1'b0;
        final_word   = 1'b0;
        next_ph      = PH_LEN;
        items_dec    = r_items_left - 32'd1;
        words_dec    = r_words_left - 32'd1;
        in_record    = (r_phase inside {[PH_ALPHA:PH_TDST]});

        if (!in_record) begin
            // Length word opens a record
            if (s <= 32'sd0) begin
                err = ard_pkg::ERR_LEN_SHORT;
            end else if (i_req.last_in_buffer) begin
                err = ard_pkg::ERR_TRUNC;
            end else begin
                n_words_left = i_req.word;
                n_phase      = PH_ALPHA;
            end
        end else begin
            case (r_phase)
                PH_ALPHA: begin
                    n_alpha = i_req.word;
                    kind    = ard_pkg::KIND_ALPHA;
                    next_ph = PH_SCOUNT;
                end
                PH_SCOUNT: begin
                    n_scount = i_req.word;
                    kind     = ard_pkg::KIND_SCOUNT;
                    next_ph  = PH_ICOUNT;
                end
                PH_ICOUNT: begin
                    if (s > 32'sd0) begin
                        n_items_left = i_req.word;
                        next_ph      = PH_IST;
                    end else begin
                        next_ph = PH_FCOUNT;
                    end
                end
                PH_FCOUNT: begin
                    if (s > 32'sd0) begin
                        n_items_left = i_req.word;
                        next_ph      = PH_FST;
                    end else begin
                        next_ph = PH_TCOUNT;
                    end
                end
                PH_IST, PH_FST: begin
                    if (s >= sc) begin
                        err = ard_pkg::ERR_STATE;
                    end else begin
                        kind = (r_phase == PH_IST) ? ard_pkg::KIND_INIT
                                                   : ard_pkg::KIND_FINAL;
                    end
                    n_items_left = items_dec;
                    if (items_dec != 32'd0) begin
                        next_ph = r_phase;
                    end else begin
                        next_ph = (r_phase == PH_IST) ? PH_FCOUNT : PH_TCOUNT;
                    end
                end
                PH_TCOUNT: begin
                    if (s > 32'sd0) begin
                        n_items_left = i_req.word;
                        next_ph      = PH_TSRC;
                    end else begin
                        final_word = 1'b1;
                    end
                end
                PH_TSRC: begin
                    // only the check result is kept here; the value goes back
                    n_src_ok = (s >= 32'sd0) && (s < sc);
                    hold     = ard_pkg::HOLD_SRC;
                    next_ph  = PH_TLAB;
                end
                PH_TLAB: begin
                    n_lab_ok = (s >= -32'sd1) && (s < alpha_s);
                    hold     = ard_pkg::HOLD_LABEL;
                    next_ph  = PH_TDST;
                end
                default: begin
                    // transition destination
                    if (!(r_src_ok && r_lab_ok && (s >= 32'sd0) && (s < sc))) begin
                        err = ard_pkg::ERR_TRANS;
                    end else begin
                        kind = ard_pkg::KIND_TRANS;
                    end
                    n_items_left = items_dec;
                    if (items_dec == 32'd0) begin
                        final_word = 1'b1;
                    end else begin
                        next_ph = PH_TSRC;
                    end
                end
            endcase

            // Record length bookkeeping
            if (err == ard_pkg::ERR_NONE) begin
                n_words_left = words_dec;
                if (final_word) begin
                    if (words_dec != 32'd0) begin
                        err = ard_pkg::ERR_LEN_LONG;
                    end else begin
                        done = 1'b1;
                    end
                    n_phase = PH_LEN;
                end else if (words_dec == 32'd0) begin
                    err = ard_pkg::ERR_LEN_SHORT;
                end else if (i_req.last_in_buffer) begin
                    err = ard_pkg::ERR_TRUNC;
                end else begin
                    n_phase = next_ph;
                end
            end
        end

        // Any error drops the record
        if (err != ard_pkg::ERR_NONE) begin
            n_phase      = PH_LEN;
            n_words_left = 32'd0;
            n_alpha      = 32'd0;
            n_scount     = 32'd0;
            n_items_left = 32'd0;
            n_src_ok     = 1'b0;
            n_lab_ok     = 1'b0;
            kind         = ard_pkg::KIND_NONE;
            hold         = ard_pkg::HOLD_NONE;
        end
    end

    assign o_cmd.kind = kind;
    assign o_cmd.hold = hold;
    assign o_cmd.word = i_req.word;
    assign o_cmd.done = done;
    assign o_cmd.err  = err;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_words_left <= 32'd0;
            r_alpha      <= 32'd0;
            r_scount     <= 32'd0;
            r_items_left <= 32'd0;
            r_src_ok     <= 1'b0;
            r_lab_ok     <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_words_left <= n_words_left;
            r_alpha      <= n_alpha;
            r_scount     <= n_scount;
            r_items_left <= n_items_left;
            r_src_ok     <= n_src_ok;
            r_lab_ok     <= n_lab_ok;
        end
    end

endmodule

### hw/rtl/ard_queue.sv
// ============================================================================
// ard_queue - command queue
// Two-entry FIFO between parser and output builder so each side can stall
// on its own.
// ============================================================================
module ard_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ard_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ard_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(ard_pkg::QDEPTH);
    localparam int CW = $clog2(ard_pkg::QDEPTH + 1);

    ard_pkg::t_cmd r_mem [ard_pkg::QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(ard_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(ard_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(ard_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/ard_back.sv
// ============================================================================
// ard_back - output builder
// Holds transition source and label words, assembles each result from a
// command and keeps it in the output register until taken.
// ============================================================================
module ard_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ard_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ard_pkg::t_out_req o_out_req
);

    logic               r_out_valid;
    ard_pkg::t_out_req  r_out_req;
    ard_pkg::t_out_req  n_out_req;
    logic signed [31:0] r_held_src;
    logic signed [31:0] r_held_lab;
    logic               is_elem;
    logic               is_trans;

    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // Result assembly
    always_comb begin
        is_elem  = (i_cmd.kind inside {[ard_pkg::KIND_ALPHA:ard_pkg::KIND_FINAL]});
        is_trans = (i_cmd.kind == ard_pkg::KIND_TRANS);
        n_out_req.elem_kind    = i_cmd.kind;
        n_out_req.elem_value   = is_elem  ? i_cmd.word : 32'sd0;
        n_out_req.trans_source = is_trans ? r_held_src : 32'sd0;
        n_out_req.trans_label  = is_trans ? r_held_lab : 32'sd0;
        n_out_req.trans_dest   = is_trans ? i_cmd.word : 32'sd0;
        n_out_req.record_done  = i_cmd.done;
        n_out_req.error_code   = i_cmd.err;
    end

    // Held transition words
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.hold == ard_pkg::HOLD_SRC)) begin
            r_held_src <= i_cmd.word;
        end
        if (o_pop && (i_cmd.hold == ard_pkg::HOLD_LABEL)) begin
            r_held_lab <= i_cmd.word;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

### hw/rtl/automaton_record_deserializer.sv
// ============================================================================
// automaton_record_deserializer - serialized automaton record decoder
// Checks a stream of 32-bit record words and emits one result per word.
// ============================================================================
//
//  channel  direction  handshake               payload
//  in       input      i_in_valid / o_in_stall  i_in_req  (t_in_req)
//  out      output     o_out_valid / i_out_stall o_out_req (t_out_req)
//
//  One word is taken every cycle while the queue is not full; each word's
//  result goes from the parser into the queue, then the output register.
//  The parse state is updated in the cycle the word is taken, so the next
//  word may follow at once.
//  Reset is synchronous, active low; the block starts expecting a length word.
//  A stalled output fills the two-entry queue; o_in_stall rises once it is full.
//
module automaton_record_deserializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ard_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ard_pkg::t_out_req o_out_req
);

    logic          in_accept;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    ard_pkg::t_cmd front_cmd;
    ard_pkg::t_cmd q_cmd;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // Parser
    ard_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_req    (i_in_req),
        .o_cmd    (front_cmd)
    );

    // Command queue
    ard_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Output builder
    ard_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

### hw/rtl/ard_checker.sv
// ============================================================================
// ard_checker - port-level checks
// Watches the top level's ports for result formatting and backpressure rules.
// ============================================================================
module ard_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input ard_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input ard_pkg::t_out_req o_out_req
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Input backpressure only while a result waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // An error result carries no element
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.error_code != ard_pkg::ERR_NONE) |->
            (o_out_req.elem_kind == ard_pkg::KIND_NONE) &&
            (o_out_req.elem_value == 32'sd0) && !o_out_req.record_done)
        else $error("error result carries data");

    // A transition never carries a scalar value
    a_trans_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.elem_kind == ard_pkg::KIND_TRANS) |->
            (o_out_req.elem_value == 32'sd0) &&
            (o_out_req.error_code == ard_pkg::ERR_NONE))
        else $error("transition result malformed");

    // Scalar elements leave the transition fields clear
    a_elem_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.elem_kind != ard_pkg::KIND_TRANS) |->
            (o_out_req.trans_source == 32'sd0) &&
            (o_out_req.trans_label == 32'sd0) &&
            (o_out_req.trans_dest == 32'sd0))
        else $error("transition fields set on non-transition result");

endmodule

bind automaton_record_deserializer ard_checker u_ard_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the automaton record deserializer
// Walks a short table of hand-built records, then a long random mix of
// well-formed records, damaged records and stray words. Every accepted word
// is run through a local decoder model; every result is compared in order.
// ============================================================================
module tb_top;

    localparam int RANDOM_WORDS = 700;
    localparam int LIMIT_CYCLES = 200000;
    localparam int REPORT_MAX   = 10;
    localparam logic signed [31:0] EPSILON = -32'sd1;

    // Decoder phases of the local model
    localparam logic [3:0] DEC_LEN         = 4'd0;
    localparam logic [3:0] DEC_ALPHA       = 4'd1;
    localparam logic [3:0] DEC_STATES      = 4'd2;
    localparam logic [3:0] DEC_INIT_COUNT  = 4'd3;
    localparam logic [3:0] DEC_INIT        = 4'd4;
    localparam logic [3:0] DEC_FINAL_COUNT = 4'd5;
    localparam logic [3:0] DEC_FINAL       = 4'd6;
    localparam logic [3:0] DEC_TRANS_COUNT = 4'd7;
    localparam logic [3:0] DEC_SRC         = 4'd8;
    localparam logic [3:0] DEC_LABEL       = 4'd9;
    localparam logic [3:0] DEC_DEST        = 4'd10;

    // One table row; typed rows carry a known error result
    typedef struct packed {
        logic signed [31:0] word;
        logic               last;
        logic               typed;
        logic [2:0]         err;
    } t_dir_row;

    typedef struct packed {
        ard_pkg::t_in_req  req;
        logic              typed;
        ard_pkg::t_out_req result;
    } t_planned_word;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    ard_pkg::t_in_req  in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    ard_pkg::t_out_req out_req;

    automaton_record_deserializer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    t_planned_word      word_plan [$];
    ard_pkg::t_out_req  pending_results [$];
    logic signed [31:0] record_body [$];
    t_dir_row           directed_rows [0:27];

    int accepted      = 0;
    int shown         = -1;
    int fail_count    = 0;
    int report_count  = 0;
    int checked_count = 0;
    int records_done  = 0;
    int error_results = 0;

    // Local decoder state
    logic [3:0]         dec_phase      = DEC_LEN;
    logic [31:0]        dec_words_left = '0;
    logic signed [31:0] dec_alpha      = '0;
    logic signed [31:0] dec_states     = '0;
    logic [31:0]        dec_items_left = '0;
    logic signed [31:0] dec_src        = '0;
    logic signed [31:0] dec_label      = '0;

    // ------------------------------------------------------------------------
    // Decoder model: one word in, one result out, state updated in place
    // ------------------------------------------------------------------------
    task automatic decode_word(input ard_pkg::t_in_req rq, output ard_pkg::t_out_req res);
        logic signed [31:0] w;
        logic signed [31:0] val, tsrc, tlab, tdst;
        logic [2:0]         kind, err;
        logic               closing, done;
        logic [3:0]         nxt;
        w    = rq.word;
        kind = ard_pkg::KIND_NONE;
        err  = ard_pkg::ERR_NONE;
        val  = '0;
        tsrc = '0;
        tlab = '0;
        tdst = '0;
        closing = 1'b0;
        done    = 1'b0;
        nxt     = DEC_LEN;
        if (dec_phase == DEC_LEN) begin
            if (w <= 0)
                err = ard_pkg::ERR_LEN_SHORT;
            else if (rq.last_in_buffer)
                err = ard_pkg::ERR_TRUNC;
            else begin
                dec_words_left = w;
                dec_phase      = DEC_ALPHA;
            end
        end else begin
            case (dec_phase)
                DEC_ALPHA: begin
                    dec_alpha = w;
                    kind = ard_pkg::KIND_ALPHA;
                    val  = w;
                    nxt  = DEC_STATES;
                end
                DEC_STATES: begin
                    dec_states = w;
                    kind = ard_pkg::KIND_SCOUNT;
                    val  = w;
                    nxt  = DEC_INIT_COUNT;
                end
                DEC_INIT_COUNT, DEC_FINAL_COUNT: begin
                    // a count that is not positive means an empty list
                    if (w > 0) begin
                        dec_items_left = w;
                        nxt = (dec_phase == DEC_INIT_COUNT) ? DEC_INIT : DEC_FINAL;
                    end else begin
                        nxt = (dec_phase == DEC_INIT_COUNT) ? DEC_FINAL_COUNT
                                                            : DEC_TRANS_COUNT;
                    end
                end
                DEC_INIT, DEC_FINAL: begin
                    // negative states pass, only the upper bound is checked
                    if (w >= dec_states)
                        err = ard_pkg::ERR_STATE;
                    else begin
                        kind = (dec_phase == DEC_INIT) ? ard_pkg::KIND_INIT
                                                       : ard_pkg::KIND_FINAL;
                        val  = w;
                    end
                    dec_items_left = dec_items_left - 32'd1;
                    if (dec_items_left != 0)
                        nxt = dec_phase;
                    else
                        nxt = (dec_phase == DEC_INIT) ? DEC_FINAL_COUNT : DEC_TRANS_COUNT;
                end
                DEC_TRANS_COUNT: begin
                    if (w > 0) begin
                        dec_items_left = w;
                        nxt = DEC_SRC;
                    end else begin
                        closing = 1'b1;
                    end
                end
                DEC_SRC: begin
                    dec_src = w;
                    nxt = DEC_LABEL;
                end
                DEC_LABEL: begin
                    dec_label = w;
                    nxt = DEC_DEST;
                end
                default: begin
                    if (dec_label < EPSILON || dec_label >= dec_alpha ||
                        dec_src < 0 || dec_src >= dec_states ||
                        w < 0 || w >= dec_states)
                        err = ard_pkg::ERR_TRANS;
                    else begin
                        kind = ard_pkg::KIND_TRANS;
                        tsrc = dec_src;
                        tlab = dec_label;
                        tdst = w;
                    end
                    dec_items_left = dec_items_left - 32'd1;
                    if (dec_items_left == 0)
                        closing = 1'b1;
                    else
                        nxt = DEC_SRC;
                end
            endcase

            // length bookkeeping; a range error of the word wins
            if (err == ard_pkg::ERR_NONE) begin
                dec_words_left = dec_words_left - 32'd1;
                if (closing) begin
                    if (dec_words_left != 0)
                        err = ard_pkg::ERR_LEN_LONG;
                    else
                        done = 1'b1;
                    dec_phase = DEC_LEN;
                end else if (dec_words_left == 0) begin
                    err = ard_pkg::ERR_LEN_SHORT;
                end else if (rq.last_in_buffer) begin
                    err = ard_pkg::ERR_TRUNC;
                end else begin
                    dec_phase = nxt;
                end
            end
        end

        res = '0;
        if (err != ard_pkg::ERR_NONE) begin
            dec_phase      = DEC_LEN;
            dec_words_left = '0;
            dec_alpha      = '0;
            dec_states     = '0;
            dec_items_left = '0;
            dec_src        = '0;
            dec_label      = '0;
            res.error_code = err;
        end else begin
            res.elem_kind    = kind;
            res.elem_value   = val;
            res.trans_source = tsrc;
            res.trans_label  = tlab;
            res.trans_dest   = tdst;
            res.record_done  = done;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------------
    task automatic plan_word(input logic signed [31:0] w, input logic last,
                             input logic typed, input logic [2:0] err);
        t_planned_word p;
        p                    = '0;
        p.req.word           = w;
        p.req.last_in_buffer = last;
        p.typed              = typed;
        p.result.error_code  = err;
        word_plan = {word_plan, p};
    endtask

    // append one word to the record being built
    task automatic add_body(input logic signed [31:0] w);
        record_body = {record_body, w};
    endtask

    function automatic logic signed [31:0] pick_state(input logic signed [31:0] n_states);
        if (n_states > 0 && n_states <= 6)
            return $urandom_range(0, n_states - 1);
        return $urandom_range(0, 3);
    endfunction

    // list count; an empty list is sometimes sent as a negative count
    task automatic push_count(input int n);
        if (n == 0 && $urandom_range(0, 2) == 0)
            add_body($urandom | 32'h8000_0000);
        else
            add_body(n);
    endtask

    task automatic plan_state_list(input logic signed [31:0] n_states);
        int                 n, r;
        logic signed [31:0] st;
        n = $urandom_range(0, 3);
        push_count(n);
        repeat (n) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                st = n_states + $urandom_range(0, 2);
            else if (r < 3)
                st = $urandom | 32'h8000_0000;
            else
                st = pick_state(n_states);
            add_body(st);
        end
    endtask

    // One random record, mostly well formed
    task automatic plan_record();
        logic signed [31:0] alpha, n_states, src, lab, dst;
        int                 n_trans, len, r, cut;
        logic               end_last;
        record_body = {};
        alpha    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
        n_states = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
        add_body(alpha);
        add_body(n_states);
        plan_state_list(n_states);
        plan_state_list(n_states);
        n_trans = $urandom_range(0, 3);
        push_count(n_trans);
        repeat (n_trans) begin
            src = pick_state(n_states);
            dst = pick_state(n_states);
            if (alpha >= 0 && alpha <= 4)
                lab = int'($urandom_range(0, alpha)) - 1;
            else
                lab = int'($urandom_range(0, 4)) - 1;
            case ($urandom_range(0, 11))
                0: src = -32'sd1;
                1: lab = alpha;
                2: dst = n_states;
                3: lab = -32'sd2;
                default: ;
            endcase
            add_body(src);
            add_body(lab);
            add_body(dst);
        end

        // damage the length now and then
        len = record_body.size();
        r = $urandom_range(0, 29);
        if (r < 3)
            len = len + $urandom_range(1, 2);
        else if (r < 6)
            len = len - $urandom_range(1, 2);
        else if (r == 6)
            len = $urandom | 32'h8000_0000;

        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, record_body.size() - 1) : -1;
        end_last = 1'($urandom_range(0, 1));
        plan_word(len, $urandom_range(0, 29) == 0, 1'b0, ard_pkg::ERR_NONE);
        foreach (record_body[i])
            plan_word(record_body[i],
                      (i == cut) || (i == record_body.size() - 1 && end_last),
                      1'b0, ard_pkg::ERR_NONE);
    endtask

    // ------------------------------------------------------------------------
    // Result check against the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_result(input ard_pkg::t_out_req want, input ard_pkg::t_out_req got);
        checked_count++;
        if (got.record_done === 1'b1)
            records_done++;
        if (got.error_code !== ard_pkg::ERR_NONE)
            error_results++;
        if (got.elem_kind !== want.elem_kind || got.elem_value !== want.elem_value ||
            got.trans_source !== want.trans_source ||
            got.trans_label !== want.trans_label ||
            got.trans_dest !== want.trans_dest ||
            got.record_done !== want.record_done ||
            got.error_code !== want.error_code) begin
            fail_count++;
            if (report_count < REPORT_MAX) begin
                report_count++;
                $display("MISMATCH result %0d: exp kind=%0d val=%0d src=%0d lab=%0d",
                         checked_count, want.elem_kind, want.elem_value,
                         want.trans_source, want.trans_label);
                $display("    exp dst=%0d done=%0b err=%0d",
                         want.trans_dest, want.record_done, want.error_code);
                $display("    got kind=%0d val=%0d src=%0d lab=%0d",
                         got.elem_kind, got.elem_value, got.trans_source,
                         got.trans_label);
                $display("    got dst=%0d done=%0b err=%0d",
                         got.trans_dest, got.record_done, got.error_code);
            end
        end
    endtask

    // Output check first, then prediction for the request taken this edge
    always @(posedge clk) begin : monitor
        ard_pkg::t_out_req predicted;
        ard_pkg::t_out_req expected;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (report_count < REPORT_MAX) begin
                        report_count++;
                        $display("UNEXPECTED result with nothing pending: err=%0d kind=%0d",
                                 out_req.error_code, out_req.elem_kind);
                    end
                end else begin
                    check_result(pending_results.pop_front(), out_req);
                end
            end
            if (in_valid && !in_stall) begin
                decode_word(word_plan[accepted].req, predicted);
                expected = word_plan[accepted].typed ? word_plan[accepted].result
                                                     : predicted;
                pending_results = {pending_results, expected};
                accepted++;
            end
        end
    end

    // No idling near the end, and none in every fourth stretch
    function automatic logic no_idling();
        return (accepted + 100 >= word_plan.size()) || ((accepted / 80) % 4 == 3);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    int gap_left = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && shown == accepted) begin
                // request still waiting, hold it
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (accepted >= word_plan.size()) begin
                in_valid <= 1'b0;
            end else if (!no_idling() && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(1, 7) - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_req   <= word_plan[accepted].req;
                shown    = accepted;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts plus one long hold-off
    // ------------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left  = 0;
    logic hold_done = 1'b0;
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && accepted >= 300) begin
            hold_done = 1'b1;
            hold_left = 150;
            out_stall <= 1'b1;
        end else if (no_idling()) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d of %0d words taken, %0d results pending",
                 cycles, accepted, word_plan.size(), pending_results.size());
        $display("automaton_record_deserializer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        directed_rows = '{
            // length word errors: zero, most negative, truncated at max length
            '{32'sd0,          1'b0, 1'b1, ard_pkg::ERR_LEN_SHORT},
            '{32'h8000_0000,   1'b0, 1'b1, ard_pkg::ERR_LEN_SHORT},
            '{32'h7FFF_FFFF,   1'b1, 1'b1, ard_pkg::ERR_TRUNC},
            // minimum alphabet, no states, initial state out of range
            '{32'sd5,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'h8000_0000,   1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b1, ard_pkg::ERR_STATE},
            // complete record: negative initial state, epsilon transition,
            // last-in-buffer set on the closing word
            '{32'sd10,         1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd2,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd3,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{-32'sd7,         1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd2,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{-32'sd1,         1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd2,          1'b1, 1'b0, ard_pkg::ERR_NONE},
            // max alphabet, negative final count, label below epsilon
            '{32'sd8,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'h7FFF_FFFF,   1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'h8000_0000,   1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd1,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{-32'sd2,         1'b0, 1'b0, ard_pkg::ERR_NONE},
            '{32'sd0,          1'b0, 1'b1, ard_pkg::ERR_TRANS}
        };
        foreach (directed_rows[i])
            plan_word(directed_rows[i].word, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].err);
        while (word_plan.size() < $size(directed_rows) + RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                plan_word($urandom, $urandom_range(0, 1), 1'b0, ard_pkg::ERR_NONE);
            else
                plan_record();
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        wait (accepted == word_plan.size());
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Ran %0d words (%0d from the table), checked %0d results",
                 word_plan.size(), $size(directed_rows), checked_count);
        $display("Records completed: %0d, error results: %0d, failures: %0d",
                 records_done, error_results, fail_count);
        if (fail_count == 0)
            $display("automaton_record_deserializer verification clean");
        else
            $display("automaton_record_deserializer verification failed");
        $finish;
    end

endmodule
